### hdl/snm_pkg.sv
// Shared constants, types and helpers for the Sobel normal-map stream.
// Used by the top level; no dependencies.
package snm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_BITS        = 8;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int RESET_SIZE      = 256;

    localparam int S_TDATA_BITS = 8;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 24;

    localparam int TUSER_FRAME_FIRST = 0;
    localparam int TUSER_DRAIN       = 1;

    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [7:0]  BLUE_LEVEL  = 8'd255;
    localparam logic [11:0] GRAD_OFFSET = 12'd128;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    function automatic logic [7:0] sat_u8(input logic [11:0] v);
        logic [7:0] r;
        if (v[11]) begin
            r = 8'd0;
        end else if (v[10:8] != 3'd0) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

### hdl/snm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first on a same-address collision; no dependencies.
module snm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sobel_normal_map_stream.sv
// Sobel 3x3 normal-map filter: top level with line buffers, window and output queue.
// Depends on snm_pkg and snm_ram.
//
// Height pixels enter in raster order, one request per cycle unless stalled; each result is
// registered and queued after the request that completes its window; edge samples are
// replicated. The two line buffers are RAMs read and written once per cycle, and a
// four-entry output queue lets input continue while a result waits. The frame size is taken
// from the configuration registers when a frame starts. After the last pixel, width + 1
// drain requests deliver the rest, or width on a single-row frame, whose input is held off
// for one cycle after the last pixel. The line buffers need no clearing after reset.
module sobel_normal_map_stream #(
    parameter int MAX_WIDTH  = snm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = snm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [snm_pkg::S_TDATA_BITS-1:0]   s_tdata,    // height_pixel
    input  logic [snm_pkg::S_TUSER_BITS-1:0]   s_tuser,    // frame_first, drain
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [snm_pkg::M_TDATA_BITS-1:0]   m_tdata,    // blue_out, green_out, red_out
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  snm_pkg::cfg_index_t                cfg_index,
    input  logic [snm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import snm_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int DW  = $clog2(MAX_WIDTH + 2);
    localparam int PW  = $clog2(OUT_FIFO_DEPTH);
    localparam int FCW = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int RESET_W = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
    localparam int RESET_H = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

    typedef struct packed {
        logic                valid;
        logic                pixel;
        logic [PIX_BITS-1:0] pix;
        logic [CW-1:0]       addr;
        logic                top_clamp;
        logic                col_first;
        logic                col_last;
        logic                emit;
        logic                last;
    } ev_t;

    // Configuration and frame control.
    logic [WW-1:0] cfg_w_reg, frame_w_reg, cfg_w_clamp, cur_fw;
    logic [HW-1:0] cfg_h_reg, frame_h_reg, cfg_h_clamp, cur_fh;
    logic [CW-1:0] col_reg, pos_c, col_next;
    logic [RW-1:0] row_reg, pos_r, row_next;
    logic [DW-1:0] drain_left_reg, drain_load;
    logic          started_reg, complete_reg, fill_reg;
    logic          accept, px_acc, dr_acc, start, ev_go, col_last, row_last, px_last;

    // Pipeline.
    ev_t           ev1_reg, ev1_next;
    logic [7:0]    up_q, mid_q, mid_v, up_v, top_v, bot_v;
    logic          fwd, wr_en;
    logic          wr_valid_reg;
    logic [CW-1:0] wr_addr_reg;
    logic [7:0]    wr_mid_reg, wr_up_reg;
    logic [9:0]    vs_new, l_vs_reg, c_vs_reg, r_vs_reg, vs_l, vs_r;
    logic [8:0]    dy_new, l_dy_reg, c_dy_reg, r_dy_reg, dy_l, dy_r;
    logic          c_first_reg, c_last_reg, r_first_reg, r_last_reg;
    logic          emit2_reg, last2_reg, emit1;
    logic [11:0]   gx_off, gy_off;

    // Output queue.
    logic [M_TDATA_BITS-1:0] fifo_data_reg [OUT_FIFO_DEPTH];
    logic                    fifo_last_reg [OUT_FIFO_DEPTH];
    logic [PW-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [FCW-1:0]          fifo_count_reg;
    logic                    push, pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data[CFG_WIDTH_BITS-1:0] == '0) begin
            cfg_w_clamp = WW'(1);
        end else if (32'(cfg_data[CFG_WIDTH_BITS-1:0]) > MAX_WIDTH) begin
            cfg_w_clamp = WW'(MAX_WIDTH);
        end else begin
            cfg_w_clamp = WW'(cfg_data[CFG_WIDTH_BITS-1:0]);
        end
        if (cfg_data[CFG_HEIGHT_BITS-1:0] == '0) begin
            cfg_h_clamp = HW'(1);
        end else if (32'(cfg_data[CFG_HEIGHT_BITS-1:0]) > MAX_HEIGHT) begin
            cfg_h_clamp = HW'(MAX_HEIGHT);
        end else begin
            cfg_h_clamp = HW'(cfg_data[CFG_HEIGHT_BITS-1:0]);
        end
    end

    assign emit1    = ev1_reg.valid & ev1_reg.emit;
    assign s_tready = ~fill_reg
                    & ((32'(fifo_count_reg) + 32'(emit1) + 32'(emit2_reg)) < OUT_FIFO_DEPTH);
    assign accept   = s_tvalid & s_tready;
    assign px_acc   = accept & ~s_tuser[TUSER_DRAIN];
    assign dr_acc   = accept & s_tuser[TUSER_DRAIN] & (drain_left_reg != '0);
    assign start    = px_acc & (s_tuser[TUSER_FRAME_FIRST] | ~started_reg | complete_reg);
    assign ev_go    = px_acc | dr_acc | fill_reg;

    assign cur_fw   = start ? cfg_w_reg : frame_w_reg;
    assign cur_fh   = start ? cfg_h_reg : frame_h_reg;
    assign pos_c    = start ? '0 : col_reg;
    assign pos_r    = start ? '0 : row_reg;
    assign col_last = (WW'(pos_c) + WW'(1)) == cur_fw;
    assign row_last = (pos_r + RW'(1)) == RW'(cur_fh);
    assign px_last  = px_acc & col_last & row_last;
    assign col_next = col_last ? '0 : pos_c + CW'(1);
    assign row_next = pos_r + RW'(col_last);
    assign drain_load = (cur_fh == HW'(1)) ? DW'(cur_fw) : DW'(cur_fw) + DW'(1);

    always_comb begin
        ev1_next.valid     = ev_go;
        ev1_next.pixel     = px_acc;
        ev1_next.pix       = s_tdata[PIX_BITS-1:0];
        ev1_next.addr      = pos_c;
        ev1_next.top_clamp = (pos_r == RW'(1));
        ev1_next.col_first = (pos_c == '0);
        ev1_next.col_last  = col_last;
        ev1_next.emit      = (pos_r > RW'(1)) || ((pos_r == RW'(1)) && (pos_c != '0));
        ev1_next.last      = dr_acc & (drain_left_reg == DW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg      <= WW'(RESET_W);
            cfg_h_reg      <= HW'(RESET_H);
            frame_w_reg    <= WW'(RESET_W);
            frame_h_reg    <= HW'(RESET_H);
            col_reg        <= '0;
            row_reg        <= '0;
            started_reg    <= 1'b0;
            complete_reg   <= 1'b0;
            fill_reg       <= 1'b0;
            drain_left_reg <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  cfg_w_reg <= cfg_w_clamp;
                    REG_IMAGE_HEIGHT: cfg_h_reg <= cfg_h_clamp;
                endcase
            end
            if (ev_go) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (start) begin
                frame_w_reg    <= cfg_w_reg;
                frame_h_reg    <= cfg_h_reg;
                started_reg    <= 1'b1;
                complete_reg   <= 1'b0;
                drain_left_reg <= '0;
            end
            if (px_last) begin
                complete_reg   <= 1'b1;
                drain_left_reg <= drain_load;
            end else if (dr_acc) begin
                drain_left_reg <= drain_left_reg - DW'(1);
            end
            fill_reg <= px_last & (cur_fh == HW'(1));
        end
    end

    snm_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) row_store_upper (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ev1_reg.addr),
        .wr_data (mid_v),
        .rd_addr (pos_c),
        .rd_data (up_q)
    );

    snm_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) row_store_middle (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ev1_reg.addr),
        .wr_data (ev1_reg.pix),
        .rd_addr (pos_c),
        .rd_data (mid_q)
    );

    // The column written on the previous cycle is forwarded when it is read again at once.
    assign fwd    = wr_valid_reg && (wr_addr_reg == ev1_reg.addr);
    assign mid_v  = fwd ? wr_mid_reg : mid_q;
    assign up_v   = fwd ? wr_up_reg : up_q;
    assign top_v  = ev1_reg.top_clamp ? mid_v : up_v;
    assign bot_v  = ev1_reg.pixel ? ev1_reg.pix : mid_v;
    assign wr_en  = ev1_reg.valid & ev1_reg.pixel;
    assign vs_new = {2'b00, top_v} + {1'b0, mid_v, 1'b0} + {2'b00, bot_v};
    assign dy_new = {1'b0, bot_v} - {1'b0, top_v};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev1_reg.valid <= 1'b0;
            wr_valid_reg  <= 1'b0;
            emit2_reg     <= 1'b0;
        end else begin
            ev1_reg      <= ev1_next;
            wr_valid_reg <= wr_en;
            emit2_reg    <= emit1;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= ev1_reg.addr;
        wr_mid_reg  <= ev1_reg.pix;
        wr_up_reg   <= mid_v;
        last2_reg   <= ev1_reg.last;
        if (ev1_reg.valid) begin
            l_vs_reg    <= c_vs_reg;
            c_vs_reg    <= r_vs_reg;
            r_vs_reg    <= vs_new;
            l_dy_reg    <= c_dy_reg;
            c_dy_reg    <= r_dy_reg;
            r_dy_reg    <= dy_new;
            c_first_reg <= r_first_reg;
            c_last_reg  <= r_last_reg;
            r_first_reg <= ev1_reg.col_first;
            r_last_reg  <= ev1_reg.col_last;
        end
    end

    // Columns beyond the left or right edge repeat the centre column.
    assign vs_l   = c_first_reg ? c_vs_reg : l_vs_reg;
    assign vs_r   = c_last_reg ? c_vs_reg : r_vs_reg;
    assign dy_l   = c_first_reg ? c_dy_reg : l_dy_reg;
    assign dy_r   = c_last_reg ? c_dy_reg : r_dy_reg;
    assign gx_off = {2'b00, vs_r} - {2'b00, vs_l} + GRAD_OFFSET;
    assign gy_off = {{3{dy_l[8]}}, dy_l} + {{2{c_dy_reg[8]}}, c_dy_reg, 1'b0}
                  + {{3{dy_r[8]}}, dy_r} + GRAD_OFFSET;

    assign push = emit2_reg;
    assign pop  = m_tvalid & m_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_data_reg[wr_ptr_reg] <= {sat_u8(gx_off), sat_u8(gy_off), BLUE_LEVEL};
            fifo_last_reg[wr_ptr_reg] <= last2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fifo_count_reg <= fifo_count_reg + FCW'(push) - FCW'(pop);
        end
    end

    assign m_tvalid = (fifo_count_reg != '0);
    assign m_tdata  = fifo_data_reg[rd_ptr_reg];
    assign m_tlast  = fifo_last_reg[rd_ptr_reg];

    a_queue_credit : assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(fifo_count_reg) + 32'(emit1) + 32'(emit2_reg)) <= OUT_FIFO_DEPTH)
        else $error("output queue reservation exceeded");

    a_fill_single : assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg |=> !fill_reg)
        else $error("fill event repeated");

    a_drain_complete : assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_left_reg != '0) |-> complete_reg)
        else $error("drain count set on an incomplete frame");

endmodule
